// ===== hw/rtl/stq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PID_W       = 8;
  localparam int TIME_W      = 64;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

  localparam logic [TIME_W-1:0] STEP_RESET = 64'd1000000000;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } act_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] dl;
    logic [PID_W-1:0]  pid;
  } entry_t;

  typedef struct packed {
    act_t              act;
    logic              head_hit;
    logic [TIME_W-1:0] key_dl;
    logic [PID_W-1:0]  key_pid;
  } row_cmd_t;

  typedef struct packed {
    logic              head_valid;
    logic [TIME_W-1:0] head_dl;
    logic [PID_W-1:0]  head_pid;
    logic              next_valid;
    logic [TIME_W-1:0] next_dl;
    logic              full;
    logic              found;
  } row_stat_t;

  typedef struct packed {
    logic             ready_res;
    logic [1:0]       status;
    logic             expired_valid;
    logic [PID_W-1:0] expired_process;
    logic             last;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stq_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface stq_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       op;
  logic [stq_pkg::TIME_W-1:0]       deadline;
  logic [stq_pkg::PID_W-1:0]        process_id;

  modport source (output valid, op, deadline, process_id, input ready);
  modport sink   (input valid, op, deadline, process_id, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stq_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface stq_out_if;
  logic                      valid;
  logic                      ready;
  logic                      ready_res;
  logic [1:0]                status;
  logic                      expired_valid;
  logic [stq_pkg::PID_W-1:0] expired_process;
  logic                      last;

  modport source (output valid, ready_res, status, expired_valid, expired_process, last,
                  input ready);
  modport sink   (input valid, ready_res, status, expired_valid, expired_process, last,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  stq_pkg::row_cmd_t cmd,
  input  stq_pkg::entry_t   left,
  input  logic              left_key_after,
  input  stq_pkg::entry_t   right,
  input  logic              hit_in,
  output stq_pkg::entry_t   ent,
  output logic              key_after,
  output logic              hit_out
);

  logic                       valid_r;
  logic [stq_pkg::TIME_W-1:0] dl_r;
  logic [stq_pkg::PID_W-1:0]  pid_r;
  stq_pkg::entry_t            ent_nxt;

  assign ent = '{valid: valid_r, dl: dl_r, pid: pid_r};

  // new key goes after every entry with a deadline not later than it
  assign key_after = valid_r && (cmd.key_dl >= dl_r);
  assign hit_out   = hit_in || (valid_r && (cmd.key_dl == dl_r) && (cmd.key_pid == pid_r));

  always_comb begin
    ent_nxt = ent;
    case (cmd.act)
      stq_pkg::ACT_INSERT: begin
        if (!key_after) begin
          if (left_key_after) begin
            ent_nxt = '{valid: 1'b1, dl: cmd.key_dl, pid: cmd.key_pid};
          end else begin
            ent_nxt = left;
          end
        end
      end
      stq_pkg::ACT_REMOVE: begin
        // everything from the first hit onward moves one place to the head
        if (hit_out) begin
          ent_nxt = right;
        end
      end
      default: begin
        ent_nxt = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ent_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    dl_r  <= ent_nxt.dl;
    pid_r <= ent_nxt.pid;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stq_row.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stq_row (
  input  logic               clk,
  input  logic               rst_n,
  input  stq_pkg::row_cmd_t  cmd,
  output stq_pkg::row_stat_t stat
);

  localparam int D = stq_pkg::QUEUE_DEPTH;

  stq_pkg::entry_t ent       [D];
  logic            key_after [D];
  logic            hit       [D];
  logic [D-1:0]    valid_vec;

  genvar i;
  generate
    for (i = 0; i < D; i++) begin : g_cell
      stq_pkg::entry_t left_w;
      stq_pkg::entry_t right_w;
      logic            left_key_after_w;
      logic            hit_in_w;

      if (i == 0) begin : g_first
        // virtual always-earlier neighbor in front of the head
        assign left_w           = '{valid: 1'b1, dl: '0, pid: '0};
        assign left_key_after_w = 1'b1;
        assign hit_in_w         = cmd.head_hit;
      end else begin : g_mid
        assign left_w           = ent[i-1];
        assign left_key_after_w = key_after[i-1];
        assign hit_in_w         = hit[i-1];
      end

      if (i == D - 1) begin : g_tail
        assign right_w = '0;
      end else begin : g_body
        assign right_w = ent[i+1];
      end

      stq_cell u_cell (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .left           (left_w),
        .left_key_after (left_key_after_w),
        .right          (right_w),
        .hit_in         (hit_in_w),
        .ent            (ent[i]),
        .key_after      (key_after[i]),
        .hit_out        (hit[i])
      );

      assign valid_vec[i] = ent[i].valid;
    end
  endgenerate

  assign stat.head_valid = ent[0].valid;
  assign stat.head_dl    = ent[0].dl;
  assign stat.head_pid   = ent[0].pid;
  assign stat.next_valid = ent[1].valid;
  assign stat.next_dl    = ent[1].dl;
  assign stat.full       = ent[D-1].valid;
  assign stat.found      = hit[D-1];

`ifndef SYNTHESIS
  a_occupied_from_head: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + D'(1))) == '0)
    else $error("occupied cells not contiguous from the head");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.act == stq_pkg::ACT_INSERT |-> !ent[D-1].valid)
    else $error("insert into a full row");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_timeout_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted timeout queue: a current-time counter plus a row of 16 cells holding pending
// timeouts (deadline, process id) kept in deadline order, head first. Each accepted beat
// is first registered and then executed in the cell row, where every cell compares the
// key against its own entry and shifts toward or away from its neighbor. A tick first
// advances the current time by time_step, then gives one result beat per retired entry
// (up to 16), retiring from the head one entry per cycle while the output is not
// stalled, or a single beat with no expiry when nothing is due. The block works on one
// beat at a time; in_ready is high whenever it is idle, even while a result still waits
// in the output register. time_step may be written any cycle the block is idle; after
// reset it holds 1000000000 and current time is zero.
module sorted_timeout_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  stq_in_if.sink                     in_ch,
  stq_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [stq_pkg::TIME_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } state_t;

  state_t                        state_r;
  logic [1:0]                    op_r;
  logic [stq_pkg::TIME_W-1:0]    dl_r;
  logic [stq_pkg::PID_W-1:0]     pid_r;
  logic [stq_pkg::TIME_W-1:0]    now_r;
  logic [stq_pkg::TIME_W-1:0]    step_r;
  logic [stq_pkg::RES_CNT_W-1:0] cnt_r;
  logic                          out_valid_r;
  stq_pkg::out_t                 out_r;

  stq_pkg::row_cmd_t  row_cmd;
  stq_pkg::row_stat_t row_st;
  stq_pkg::out_t      exec_res;
  logic               out_free;
  logic               out_load;
  logic               is_ready;
  logic               due;
  logic               next_due;
  logic               last_hit;

  stq_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (row_cmd),
    .stat  (row_st)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = out_free && (((state_r == S_EXEC) && (op_r != stq_pkg::OP_TICK)) ||
                                 (state_r == S_DRAIN));
  assign is_ready = now_r >= dl_r;
  assign due      = row_st.head_valid && (row_st.head_dl <= now_r);
  assign next_due = row_st.next_valid && (row_st.next_dl <= now_r);
  assign last_hit = (cnt_r == stq_pkg::RES_CNT_W'(stq_pkg::MAX_RESULTS - 1)) || !next_due;

  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.ready_res       = out_r.ready_res;
  assign out_ch.status          = out_r.status;
  assign out_ch.expired_valid   = out_r.expired_valid;
  assign out_ch.expired_process = out_r.expired_process;
  assign out_ch.last            = out_r.last;

  always_comb begin
    exec_res = '0;
    exec_res.last = 1'b1;
    case (op_r)
      stq_pkg::OP_ENABLE: begin
        exec_res.ready_res = is_ready;
        exec_res.status    = (!is_ready && row_st.full) ? stq_pkg::ST_FULL : stq_pkg::ST_OK;
      end
      stq_pkg::OP_DISABLE: begin
        exec_res.ready_res = is_ready;
        exec_res.status    = row_st.found ? stq_pkg::ST_OK : stq_pkg::ST_NOMATCH;
      end
      default: begin
        exec_res.ready_res = 1'b0;
      end
    endcase
  end

  always_comb begin
    row_cmd.act      = stq_pkg::ACT_HOLD;
    row_cmd.head_hit = 1'b0;
    row_cmd.key_dl   = dl_r;
    row_cmd.key_pid  = pid_r;
    case (state_r)
      S_EXEC: begin
        if (out_free) begin
          case (op_r)
            stq_pkg::OP_ENABLE: begin
              if (!is_ready && !row_st.full) begin
                row_cmd.act = stq_pkg::ACT_INSERT;
              end
            end
            stq_pkg::OP_DISABLE: begin
              row_cmd.act = stq_pkg::ACT_REMOVE;
            end
            default: begin
              row_cmd.act = stq_pkg::ACT_HOLD;
            end
          endcase
        end
      end
      S_DRAIN: begin
        // retire the head
        if (out_free && due) begin
          row_cmd.act      = stq_pkg::ACT_REMOVE;
          row_cmd.head_hit = 1'b1;
        end
      end
      default: begin
        row_cmd.act = stq_pkg::ACT_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      step_r      <= stq_pkg::STEP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= in_ch.op;
            dl_r    <= in_ch.deadline;
            pid_r   <= in_ch.process_id;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (op_r == stq_pkg::OP_TICK) begin
            now_r   <= now_r + step_r;
            cnt_r   <= '0;
            state_r <= S_DRAIN;
          end else if (out_free) begin
            out_r   <= exec_res;
            state_r <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            if (due) begin
              out_r <= '{ready_res: 1'b0, status: stq_pkg::ST_OK, expired_valid: 1'b1,
                          expired_process: row_st.head_pid, last: last_hit};
              cnt_r <= cnt_r + stq_pkg::RES_CNT_W'(1);
              if (last_hit) begin
                state_r <= S_IDLE;
              end
            end else begin
              // nothing due at all on this tick
              out_r   <= '{ready_res: 1'b0, status: stq_pkg::ST_OK, expired_valid: 1'b0,
                           expired_process: '0, last: 1'b1};
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_EXEC)
    else $error("accepted beat did not enter execution");

  a_retire_only_due: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN && row_cmd.act == stq_pkg::ACT_REMOVE |->
      row_st.head_valid && (row_st.head_dl <= now_r))
    else $error("retired a head entry that is not due");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN && out_free && !(due && !last_hit) |=> state_r == S_IDLE)
    else $error("tick drain did not finish after its last beat");

  a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.expired_valid |-> !out_r.ready_res && out_r.status == stq_pkg::ST_OK)
    else $error("expired beat carries enable or disable fields");
`endif

endmodule

`default_nettype wire
